// ===== design/mcw_pkg.sv =====
// Package for the multi-channel watchdog: field widths, codes, shared structs.
// Used by every module of the block except mcw_ram; depends on nothing.

package mcw_pkg;

   localparam int NUM_CHANNELS = 16;
   localparam int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

   localparam int KIND_W      = 2;
   localparam int CHAN_W      = 4;
   localparam int MS_W        = 16;
   localparam int TPM_W       = 10;
   localparam int INTERVAL_W  = 8;
   localparam int NOW_W       = 32;
   localparam int TIMEOUT_W   = MS_W + TPM_W;
   localparam int MAX_RESULTS = 16;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 10;

   typedef enum logic [KIND_W-1:0] {
      KIND_START = 2'd0,
      KIND_STOP  = 2'd1,
      KIND_FEED  = 2'd2,
      KIND_TICK  = 2'd3
   } kind_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_ENABLED       = 2'd0,
      CSR_TICKS_PER_MS  = 2'd1,
      CSR_SCAN_INTERVAL = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMD,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic                  enabled;
      logic [TPM_W-1:0]      ticks_per_ms;
      logic [INTERVAL_W-1:0] scan_interval;
   } cfg_type;

   // Access to the feed stamp and timeout memories; both share one read address.
   typedef struct packed {
      logic                 stamp_we;
      logic                 tmo_we;
      logic [IDX_W-1:0]     wr_addr;
      logic [NOW_W-1:0]     stamp_wdata;
      logic [TIMEOUT_W-1:0] tmo_wdata;
      logic                 rd_en;
      logic [IDX_W-1:0]     rd_addr;
   } ram_req_type;

endpackage

// ===== design/mcw_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stand-alone; no package dependency.

module mcw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/mcw_seq.sv =====
// Sequencer of the watchdog bank: command handling, tick count, expiry scan
// over the stamp/timeout memories, and the result register. Uses mcw_pkg.

module mcw_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  mcw_pkg::cfg_type                 cfg,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  mcw_pkg::kind_type                req_kind,
   input  logic [mcw_pkg::CHAN_W-1:0]       req_chan,
   input  logic [mcw_pkg::MS_W-1:0]         req_ms,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [mcw_pkg::CHAN_W-1:0]       rsp_chan,
   output logic                             rsp_expired,
   output logic                             rsp_ok,
   output logic                             rsp_last,
   output mcw_pkg::ram_req_type             ram_req,
   input  logic [mcw_pkg::NOW_W-1:0]        rd_stamp,
   input  logic [mcw_pkg::TIMEOUT_W-1:0]    rd_tmo
);

   mcw_pkg::state_type                    state_ff, state_in;
   logic [mcw_pkg::NOW_W-1:0]             now_ff, now_in;
   logic [mcw_pkg::INTERVAL_W-1:0]        phase_ff, phase_in;
   logic [mcw_pkg::NUM_CHANNELS-1:0]      active_ff, active_in;
   logic                                  pend_valid_ff, pend_valid_in;
   logic [mcw_pkg::IDX_W-1:0]             pend_idx_ff, pend_idx_in;
   logic [mcw_pkg::CNT_W-1:0]             found_ff, found_in;
   logic [mcw_pkg::IDX_W-1:0]             cmp_idx_ff, cmp_idx_in;

   mcw_pkg::kind_type                     cmd_kind_ff, cmd_kind_in;
   logic [mcw_pkg::CHAN_W-1:0]            cmd_chan_ff, cmd_chan_in;
   logic [mcw_pkg::MS_W-1:0]              cmd_ms_ff, cmd_ms_in;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [mcw_pkg::CHAN_W-1:0]            rsp_chan_ff, rsp_chan_in;
   logic                                  rsp_expired_ff, rsp_expired_in;
   logic                                  rsp_ok_ff, rsp_ok_in;
   logic                                  rsp_last_ff, rsp_last_in;

   logic                                  out_free;
   logic [mcw_pkg::INTERVAL_W-1:0]        phase_inc;
   logic                                  cmd_valid;
   logic [mcw_pkg::IDX_W-1:0]             cmd_idx;
   logic [mcw_pkg::NOW_W-1:0]             elapsed;
   logic                                  hit;
   logic                                  advance;
   logic                                  limit;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign phase_inc = phase_ff + 1'b1;
   assign cmd_valid = int'(cmd_chan_ff) < mcw_pkg::NUM_CHANNELS;
   assign cmd_idx   = mcw_pkg::IDX_W'(cmd_chan_ff);
   assign elapsed   = now_ff - rd_stamp;
   assign hit       = active_ff[cmp_idx_ff] && (elapsed >= mcw_pkg::NOW_W'(rd_tmo));
   // A hit while a result is pending needs the output register free to take it; the memory read holds meanwhile.
   assign advance   = !(hit && pend_valid_ff && !out_free);
   assign limit     = hit && (mcw_pkg::CNT_W'(found_ff + 1'b1) ==
                              mcw_pkg::CNT_W'(mcw_pkg::MAX_RESULTS));

   always_comb begin
      state_in       = state_ff;
      now_in         = now_ff;
      phase_in       = phase_ff;
      active_in      = active_ff;
      pend_valid_in  = pend_valid_ff;
      pend_idx_in    = pend_idx_ff;
      found_in       = found_ff;
      cmp_idx_in     = cmp_idx_ff;
      cmd_kind_in    = cmd_kind_ff;
      cmd_chan_in    = cmd_chan_ff;
      cmd_ms_in      = cmd_ms_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_chan_in    = rsp_chan_ff;
      rsp_expired_in = rsp_expired_ff;
      rsp_ok_in      = rsp_ok_ff;
      rsp_last_in    = rsp_last_ff;
      req_ready      = 1'b0;
      ram_req        = '0;

      unique case (state_ff)
         mcw_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_kind == mcw_pkg::KIND_TICK) begin
                  now_in = now_ff + 1'b1;
                  if (phase_inc < cfg.scan_interval) begin
                     phase_in = phase_inc;
                  end else begin
                     phase_in        = '0;
                     ram_req.rd_en   = 1'b1;
                     ram_req.rd_addr = '0;
                     cmp_idx_in      = '0;
                     state_in        = mcw_pkg::ST_SCAN;
                  end
               end else begin
                  cmd_kind_in = req_kind;
                  cmd_chan_in = req_chan;
                  cmd_ms_in   = req_ms;
                  state_in    = mcw_pkg::ST_CMD;
               end
            end
         end

         mcw_pkg::ST_CMD: begin
            if (out_free) begin
               rsp_ok_in = 1'b1;
               unique case (cmd_kind_ff)
                  mcw_pkg::KIND_START: begin
                     if (!cmd_valid) begin
                        rsp_ok_in = 1'b0;
                     end else if (!active_ff[cmd_idx]) begin
                        if (cfg.enabled) begin
                           ram_req.stamp_we    = 1'b1;
                           ram_req.tmo_we      = 1'b1;
                           ram_req.wr_addr     = cmd_idx;
                           ram_req.stamp_wdata = now_ff;
                           ram_req.tmo_wdata   = mcw_pkg::TIMEOUT_W'(cmd_ms_ff) *
                                                 mcw_pkg::TIMEOUT_W'(cfg.ticks_per_ms);
                           active_in[cmd_idx]  = 1'b1;
                        end else begin
                           rsp_ok_in = 1'b0;
                        end
                     end
                  end
                  mcw_pkg::KIND_STOP: begin
                     if (cmd_valid) begin
                        active_in[cmd_idx] = 1'b0;
                     end
                  end
                  mcw_pkg::KIND_FEED: begin
                     if (cmd_valid && active_ff[cmd_idx]) begin
                        ram_req.stamp_we    = 1'b1;
                        ram_req.wr_addr     = cmd_idx;
                        ram_req.stamp_wdata = now_ff;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_valid_in   = 1'b1;
               rsp_chan_in    = cmd_chan_ff;
               rsp_expired_in = 1'b0;
               rsp_last_in    = 1'b1;
               state_in       = mcw_pkg::ST_IDLE;
            end
         end

         mcw_pkg::ST_SCAN: begin
            if (advance) begin
               if (hit) begin
                  active_in[cmp_idx_ff] = 1'b0;
                  found_in              = mcw_pkg::CNT_W'(found_ff + 1'b1);
                  pend_valid_in         = 1'b1;
                  pend_idx_in           = cmp_idx_ff;
                  if (pend_valid_ff) begin
                     rsp_valid_in   = 1'b1;
                     rsp_chan_in    = mcw_pkg::CHAN_W'(pend_idx_ff);
                     rsp_expired_in = 1'b1;
                     rsp_ok_in      = 1'b1;
                     rsp_last_in    = 1'b0;
                  end
               end
               if (limit || cmp_idx_ff == mcw_pkg::LAST_IDX) begin
                  state_in = mcw_pkg::ST_FLUSH;
               end else begin
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = mcw_pkg::IDX_W'(cmp_idx_ff + 1'b1);
                  cmp_idx_in      = mcw_pkg::IDX_W'(cmp_idx_ff + 1'b1);
               end
            end
         end

         mcw_pkg::ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_ok_in      = 1'b1;
               rsp_last_in    = 1'b1;
               rsp_expired_in = pend_valid_ff;
               rsp_chan_in    = pend_valid_ff ? mcw_pkg::CHAN_W'(pend_idx_ff) : '0;
               pend_valid_in  = 1'b0;
               found_in       = '0;
               state_in       = mcw_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = mcw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mcw_pkg::ST_IDLE;
         now_ff        <= '0;
         phase_ff      <= '0;
         active_ff     <= '0;
         pend_valid_ff <= 1'b0;
         found_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         now_ff        <= now_in;
         phase_ff      <= phase_in;
         active_ff     <= active_in;
         pend_valid_ff <= pend_valid_in;
         found_ff      <= found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff    <= pend_idx_in;
      cmp_idx_ff     <= cmp_idx_in;
      cmd_kind_ff    <= cmd_kind_in;
      cmd_chan_ff    <= cmd_chan_in;
      cmd_ms_ff      <= cmd_ms_in;
      rsp_chan_ff    <= rsp_chan_in;
      rsp_expired_ff <= rsp_expired_in;
      rsp_ok_ff      <= rsp_ok_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_chan    = rsp_chan_ff;
   assign rsp_expired = rsp_expired_ff;
   assign rsp_ok      = rsp_ok_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

// ===== design/multi_channel_watchdog.sv =====
// Top level of the multi-channel watchdog: stream ports, configuration registers,
// the sequencer and the feed stamp and timeout memories. Uses mcw_pkg, mcw_seq, mcw_ram.
//
// Usage: commands enter on the req_ stream, one transaction per command; req_tuser
// carries the kind (start, stop, feed, tick). Start, stop and feed each return one
// transaction on rsp_ with tlast set. It is loaded into the output register once that
// register is free, and the next command can be taken while it is presented.
// A tick advances the tick count in the cycle it is accepted and, every
// scan_interval ticks, starts a scan of all channels. A tick with no scan gives
// nothing, and the next command can be taken in the following cycle. The scan reads
// one channel per cycle from the two memories (one read port each) while the receiver
// keeps up, and the final transaction is presented after the last channel is read;
// the next command can be taken while it is presented. Expired channels are
// reported in ascending order with tlast on the final one; a scan with no expiry
// gives one empty transaction. A new command is taken once the previous one has
// handed its last transaction to the output register, even while it still waits.
// When rsp_tready is low, the scan holds at an expired channel until the previous
// report has left. Reset clears the armed flags, the tick count and the scan phase,
// and sets the configuration registers to defaults; the memories are not cleared,
// as their contents only matter for armed channels. The csr_ port writes registers.

module multi_channel_watchdog (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [3:0] channel, [19:4] timeout (ms), [23:20] zero
   input  logic [mcw_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [1:0] kind
   input  logic [mcw_pkg::KIND_W-1:0]         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [3:0] chan_out, [4] ok, [7:5] zero
   output logic [mcw_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [0] expired
   output logic                               rsp_tuser,
   output logic                               rsp_tlast,
   input  logic                               csr_we,
   input  logic [mcw_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [mcw_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   mcw_pkg::cfg_type                   cfg_ff, cfg_in;
   mcw_pkg::ram_req_type               ram_req;
   logic [mcw_pkg::NOW_W-1:0]          rd_stamp;
   logic [mcw_pkg::TIMEOUT_W-1:0]      rd_tmo;
   logic [mcw_pkg::CHAN_W-1:0]         rsp_chan;
   logic                               rsp_ok;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            mcw_pkg::CSR_ENABLED: begin
               cfg_in.enabled = csr_wdata[0];
            end
            mcw_pkg::CSR_TICKS_PER_MS: begin
               cfg_in.ticks_per_ms = csr_wdata[mcw_pkg::TPM_W-1:0];
            end
            mcw_pkg::CSR_SCAN_INTERVAL: begin
               cfg_in.scan_interval = csr_wdata[mcw_pkg::INTERVAL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enabled       <= 1'b0;
         cfg_ff.ticks_per_ms  <= mcw_pkg::TPM_W'(1);
         cfg_ff.scan_interval <= mcw_pkg::INTERVAL_W'(2);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mcw_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_kind    (mcw_pkg::kind_type'(req_tuser)),
      .req_chan    (req_tdata[mcw_pkg::CHAN_W-1:0]),
      .req_ms      (req_tdata[mcw_pkg::CHAN_W +: mcw_pkg::MS_W]),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_chan    (rsp_chan),
      .rsp_expired (rsp_tuser),
      .rsp_ok      (rsp_ok),
      .rsp_last    (rsp_tlast),
      .ram_req     (ram_req),
      .rd_stamp    (rd_stamp),
      .rd_tmo      (rd_tmo)
   );

   mcw_ram #(
      .WIDTH (mcw_pkg::NOW_W),
      .DEPTH (mcw_pkg::NUM_CHANNELS)
   ) u_stamp_ram (
      .clock   (clock),
      .wr_en   (ram_req.stamp_we),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.stamp_wdata),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (rd_stamp)
   );

   mcw_ram #(
      .WIDTH (mcw_pkg::TIMEOUT_W),
      .DEPTH (mcw_pkg::NUM_CHANNELS)
   ) u_tmo_ram (
      .clock   (clock),
      .wr_en   (ram_req.tmo_we),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.tmo_wdata),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (rd_tmo)
   );

   assign rsp_tdata = {(mcw_pkg::RSP_DATA_W - mcw_pkg::CHAN_W - 1)'(0), rsp_ok, rsp_chan};

endmodule

// ===== design/mcw_checker.sv =====
// Port-level checks of the multi-channel watchdog, bound to the top level.
// Uses mcw_pkg for field widths; sees only the top-level ports.

module mcw_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [mcw_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic                               rsp_tuser,
   input logic                               rsp_tlast
);

   // A stalled result transaction keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                   $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result transaction changed");

   // An expiry report always carries ok.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[mcw_pkg::CHAN_W])
      else $error("expiry reported without ok");

   // Only expiry reports can be followed by more results of the same item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("non-expiry result not marked last");

   // Reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind multi_channel_watchdog mcw_checker u_mcw_checker (.*);

// ===== tb/sv/tb_multi_channel_watchdog.sv =====
// Self-checking testbench for multi_channel_watchdog: a queue-fed stream driver, a stalling
// receiver and a monitor that checks each response against an internal watchdog predictor.
// Depends on mcw_pkg and the multi_channel_watchdog RTL.

module tb_multi_channel_watchdog;

   typedef struct packed {
      mcw_pkg::kind_type kind;
      logic [3:0]        channel;
      logic [15:0]       ms;
   } wd_command_type;

   typedef struct packed {
      logic [3:0] chan;
      logic       expired;
      logic       ok;
      logic       last;
   } wd_result_type;

   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 300;
   localparam int NUM_PHASES    = 8;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [mcw_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic [mcw_pkg::KIND_W-1:0]     req_tuser  = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [mcw_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tuser;
   logic                           rsp_tlast;
   logic                           csr_we     = 1'b0;
   logic [mcw_pkg::CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [mcw_pkg::CSR_DATA_W-1:0] csr_wdata  = '0;

   multi_channel_watchdog dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // Predicted watchdog state and configuration.
   logic        cfg_enabled      = 1'b0;
   logic [9:0]  cfg_ticks_per_ms = 10'd1;
   logic [7:0]  cfg_interval     = 8'd2;
   logic [31:0] wd_now           = '0;
   logic [7:0]  wd_phase         = '0;
   logic        wd_armed [16]    = '{default: 1'b0};
   logic [31:0] wd_stamp [16];
   logic [31:0] wd_limit [16];

   wd_command_type pending_cmds[$];
   wd_result_type  expected_results[$];
   int             mismatch_count = 0;

   // Handshake and pacing state shared between the clocked processes.
   bit             req_taken     = 1'b0;
   bit             sender_steady = 1'b0;
   int             burst_left    = 1;
   int             gap_left      = 0;
   wd_command_type next_cmd;
   bit             hold_request  = 1'b0;
   bit             hold_taken    = 1'b0;
   int             hold_left     = 0;
   logic [8:0]     stall_phase   = '0;

   int phase_enabled  [0:NUM_PHASES-1] = '{1, 1, 0, 1, 1, 1, 1, 1};
   int phase_tpm      [0:NUM_PHASES-1] = '{1, 3, 1, 1000, 2, 1, 1, 5};
   int phase_interval [0:NUM_PHASES-1] = '{1, 4, 2, 255, 3, 1, 7, 2};

   initial begin
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic check_field(string name, int got, int want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   // Applies one accepted command to the predicted state and queues the responses it causes.
   task automatic predict_command(mcw_pkg::kind_type kind, logic [3:0] ch, logic [15:0] ms);
      logic [31:0] elapsed;
      logic [3:0]  hit_chan [16];
      int          hits;
      logic        ok;
      hits = 0;
      ok = 1'b1;
      case (kind)
         mcw_pkg::KIND_START: begin
            if (!wd_armed[ch]) begin
               if (cfg_enabled) begin
                  wd_limit[ch] = {16'b0, ms} * {22'b0, cfg_ticks_per_ms};
                  wd_stamp[ch] = wd_now;
                  wd_armed[ch] = 1'b1;
               end else begin
                  ok = 1'b0;
               end
            end
            expected_results.push_back('{chan: ch, expired: 1'b0, ok: ok, last: 1'b1});
         end
         mcw_pkg::KIND_STOP: begin
            wd_armed[ch] = 1'b0;
            expected_results.push_back('{chan: ch, expired: 1'b0, ok: 1'b1, last: 1'b1});
         end
         mcw_pkg::KIND_FEED: begin
            if (wd_armed[ch])
               wd_stamp[ch] = wd_now;
            expected_results.push_back('{chan: ch, expired: 1'b0, ok: 1'b1, last: 1'b1});
         end
         mcw_pkg::KIND_TICK: begin
            wd_now = wd_now + 32'd1;
            wd_phase = wd_phase + 8'd1;
            // A scan is due once the phase reaches the interval; a zero interval acts as one.
            if (wd_phase >= cfg_interval) begin
               wd_phase = '0;
               for (int i = 0; i < 16; i++) begin
                  elapsed = wd_now - wd_stamp[i];
                  if (wd_armed[i] && elapsed >= wd_limit[i]) begin
                     wd_armed[i] = 1'b0;
                     hit_chan[hits] = 4'(i);
                     hits++;
                  end
               end
               if (hits == 0)
                  expected_results.push_back('{chan: 4'd0, expired: 1'b0, ok: 1'b1, last: 1'b1});
               for (int k = 0; k < hits; k++)
                  expected_results.push_back('{chan: hit_chan[k], expired: 1'b1, ok: 1'b1,
                                               last: (k == hits - 1)});
            end
         end
      endcase
   endtask

   // Request driver: bursts of transactions separated by random gaps, or by none while the sender is steady.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_cmds.size() == 0) begin
            req_tvalid <= 1'b0;
         end else begin
            next_cmd = pending_cmds.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= next_cmd.kind;
            req_tdata  <= {4'b0, next_cmd.ms, next_cmd.channel};
            if (burst_left <= 1) begin
               burst_left = $urandom_range(12, 1);
               gap_left = sender_steady ? 0 : $urandom_range(8, 1);
            end else begin
               burst_left--;
            end
         end
      end
   end

   // Response receiver: its stall pattern steps through four modes set by stall_phase[8:7], with one long hold-off.
   always @(negedge clock) begin
      if (hold_request && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         stall_phase = stall_phase + 9'd1;
         case (stall_phase[8:7])
            2'd0: rsp_tready <= 1'b1;
            2'd1: rsp_tready <= ($urandom_range(3, 0) != 0);
            2'd2: rsp_tready <= ($urandom_range(3, 0) == 0);
            default: rsp_tready <= (stall_phase[2:0] != 3'd5);
         endcase
      end
   end

   // Monitor: predicts on each accepted command, then checks each accepted response.
   always @(posedge clock) begin
      wd_result_type want;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_tvalid && req_tready;
         if (req_taken)
            predict_command(mcw_pkg::kind_type'(req_tuser), req_tdata[3:0], req_tdata[19:4]);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("unexpected transaction chan %0d expired %0d",
                                         rsp_tdata[3:0], rsp_tuser));
            end else begin
               want = expected_results.pop_front();
               check_field("chan_out", rsp_tdata[3:0], want.chan);
               check_field("expired", rsp_tuser, want.expired);
               check_field("ok", rsp_tdata[4], want.ok);
               check_field("last", rsp_tlast, want.last);
            end
         end
      end
   end

   task automatic queue_cmd(mcw_pkg::kind_type kind, int ch, int ms);
      pending_cmds.push_back('{kind: kind, channel: 4'(ch), ms: 16'(ms)});
   endtask

   task automatic write_reg(mcw_pkg::csr_index_type idx, int value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= mcw_pkg::CSR_DATA_W'(value);
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         mcw_pkg::CSR_ENABLED:       cfg_enabled = 1'(value);
         mcw_pkg::CSR_TICKS_PER_MS:  cfg_ticks_per_ms = 10'(value);
         mcw_pkg::CSR_SCAN_INTERVAL: cfg_interval = 8'(value);
         default: ;
      endcase
   endtask

   task automatic apply_config(int enabled, int tpm, int interval);
      write_reg(mcw_pkg::CSR_ENABLED, enabled);
      write_reg(mcw_pkg::CSR_TICKS_PER_MS, tpm);
      write_reg(mcw_pkg::CSR_SCAN_INTERVAL, interval);
   endtask

   // Ticks that stop without a scan leave no response behind, so let the block settle too.
   task automatic wait_idle();
      while (pending_cmds.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_random_commands(int count);
      int pick;
      int group;
      int ticks;
      int ms;
      while (count > 0) begin
         pick = $urandom_range(99, 0);
         if (pick < 8 && count >= 6) begin
            // Arm a small group with short timeouts, then tick as often as the scan interval, at most four times.
            group = $urandom_range(5, 2);
            ticks = (cfg_interval > 4) ? 4 : cfg_interval;
            repeat (group)
               queue_cmd(mcw_pkg::KIND_START, $urandom_range(15, 0), $urandom_range(2, 0));
            repeat (ticks)
               queue_cmd(mcw_pkg::KIND_TICK, $urandom_range(15, 0), $urandom_range(65535, 0));
            count -= group + ticks;
         end else begin
            pick = $urandom_range(99, 0);
            if (pick < 55)
               ms = $urandom_range(8, 0);
            else if (pick < 80)
               ms = $urandom_range(40, 0);
            else if (pick < 92)
               ms = $urandom_range(65535, 0);
            else
               ms = pick[0] ? 65535 : 0;
            pick = $urandom_range(99, 0);
            if (pick < 18)
               queue_cmd(mcw_pkg::KIND_START, $urandom_range(15, 0), ms);
            else if (pick < 28)
               queue_cmd(mcw_pkg::KIND_STOP, $urandom_range(15, 0), ms);
            else if (pick < 48)
               queue_cmd(mcw_pkg::KIND_FEED, $urandom_range(15, 0), ms);
            else
               queue_cmd(mcw_pkg::KIND_TICK, $urandom_range(15, 0), ms);
            count--;
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset configuration: start is refused while disabled, and two ticks give an empty scan.
      queue_cmd(mcw_pkg::KIND_START, 0, 5);
      queue_cmd(mcw_pkg::KIND_STOP, 15, 0);
      queue_cmd(mcw_pkg::KIND_FEED, 3, 0);
      queue_cmd(mcw_pkg::KIND_TICK, 0, 0);
      queue_cmd(mcw_pkg::KIND_TICK, 0, 0);
      wait_idle();

      apply_config(1, 1, 1);
      queue_cmd(mcw_pkg::KIND_START, 0, 0);
      queue_cmd(mcw_pkg::KIND_START, 15, 65535);
      queue_cmd(mcw_pkg::KIND_START, 0, 7);
      queue_cmd(mcw_pkg::KIND_START, 5, 2);
      queue_cmd(mcw_pkg::KIND_FEED, 5, 0);
      queue_cmd(mcw_pkg::KIND_TICK, 0, 0);
      queue_cmd(mcw_pkg::KIND_TICK, 0, 0);
      queue_cmd(mcw_pkg::KIND_FEED, 5, 0);
      queue_cmd(mcw_pkg::KIND_TICK, 0, 0);
      queue_cmd(mcw_pkg::KIND_TICK, 0, 0);
      queue_cmd(mcw_pkg::KIND_STOP, 15, 0);
      queue_cmd(mcw_pkg::KIND_FEED, 15, 0);
      queue_cmd(mcw_pkg::KIND_START, 1, 1);
      queue_cmd(mcw_pkg::KIND_START, 2, 1);
      queue_cmd(mcw_pkg::KIND_START, 3, 1);
      queue_cmd(mcw_pkg::KIND_TICK, 0, 0);
      wait_idle();

      // Disabled with a channel still armed: start fails, scans go on.
      apply_config(1, 1, 1);
      queue_cmd(mcw_pkg::KIND_START, 9, 3);
      wait_idle();
      write_reg(mcw_pkg::CSR_ENABLED, 0);
      queue_cmd(mcw_pkg::KIND_START, 6, 1);
      queue_cmd(mcw_pkg::KIND_TICK, 0, 0);
      queue_cmd(mcw_pkg::KIND_TICK, 0, 0);
      queue_cmd(mcw_pkg::KIND_TICK, 0, 0);
      wait_idle();

      for (int p = 0; p < NUM_PHASES; p++) begin
         apply_config(phase_enabled[p], phase_tpm[p], phase_interval[p]);
         sender_steady = (p == 0 || p == 5);
         if (p == 0) begin
            // Every channel expires in the same scan.
            for (int c = 0; c < 16; c++)
               queue_cmd(mcw_pkg::KIND_START, c, 0);
            queue_cmd(mcw_pkg::KIND_TICK, 0, 0);
         end
         if (p == 5)
            hold_request = 1'b1;
         queue_random_commands(40);
         wait_idle();
      end

      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule
